@@ design/rrc_pkg.sv @@
// Shared types and constants of the rectangle raster canvas.
package rrc_pkg;

    // Default geometry of the canvas store and the coordinate format.
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;

    // Fixed field widths.
    localparam int CFG_DW   = 10;
    localparam int SIZE_W   = 11;
    localparam int COORD_W  = 19;
    localparam int LEN_W    = 18;
    localparam int CHAR_W   = 8;
    localparam int RD_POS_W = 9;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DW-1:0] RST_CANVAS_SIZE = 10'd300;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND  = 8'd32;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_COL,
        S_READ,
        S_RESULT
    } t_state;

    // Result of testing one pixel coordinate against one rectangle span.
    typedef struct packed {
        logic covered;
        logic edge_band;
    } t_span;

endpackage

@@ design/rrc_span_unit.sv @@
// Shared span test: places one pixel coordinate against a rectangle span on one axis.
module rrc_span_unit
    import rrc_pkg::*;
#(
    parameter int PW        = 9,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic [PW-1:0]             i_pos,
    input  logic signed [COORD_W-1:0] i_org,
    input  logic [LEN_W-1:0]          i_len,
    output t_span                     o_span
);

    localparam int PVW = PW + FRAC_BITS;
    localparam int DW  = ((PVW > COORD_W) ? PVW : COORD_W) + 2;
    localparam logic signed [DW-1:0] UNIT = DW'(1) << FRAC_BITS;

    logic signed [DW-1:0] pos_v;
    logic signed [DW-1:0] org_v;
    logic signed [DW-1:0] len_v;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] rem;

    // Offset of the pixel from the rectangle origin, and its distance to the far edge.
    always_comb begin
        pos_v = $signed(DW'(i_pos)) <<< FRAC_BITS;
        org_v = DW'(i_org);
        len_v = $signed(DW'(i_len));
        diff  = pos_v - org_v;
        rem   = len_v - diff;
        o_span.covered   = !diff[DW-1] && (diff <= len_v);
        o_span.edge_band = (diff < UNIT) || (rem < UNIT);
    end

endmodule

@@ design/rect_raster_canvas.sv @@
// Top level of the rectangle raster canvas: sequencer, canvas store and result register.
//
//  Channel   Direction  Handshake                     Payload
//  in        input      i_in_valid / o_in_ready       i_kind .. i_read_row
//  out       output     o_out_valid / i_out_ready     o_pixel_char, o_out_of_range
//  cfg       input      i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// A clear or draw transaction sweeps a canvas in use of W columns and H rows: each row
// span is tested once per row (S_ROW), then one pixel per cycle (S_COL), all through
// the one shared span unit and the single write port of the canvas store.
// A read transaction passes S_READ and S_RESULT before its result sits in the output register.
// Reset clears the sequencer and the result valid flag and presets the configuration registers;
// the canvas contents are undefined until written and are not cleared.
// A result waiting in the output register blocks only the next read from finishing.
module rect_raster_canvas
    import rrc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [CFG_DW-1:0]         i_cfg_data,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_kind,
    input  logic signed [COORD_W-1:0] i_rect_x,
    input  logic signed [COORD_W-1:0] i_rect_y,
    input  logic [LEN_W-1:0]          i_rect_width,
    input  logic [LEN_W-1:0]          i_rect_height,
    input  logic                      i_filled,
    input  logic [CHAR_W-1:0]         i_paint_char,
    input  logic [RD_POS_W-1:0]       i_read_col,
    input  logic [RD_POS_W-1:0]       i_read_row,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [CHAR_W-1:0]         o_pixel_char,
    output logic                      o_out_of_range
);

    localparam int AW_C = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW_R = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW   = AW_C + AW_R;
    localparam int PW   = (AW_C > AW_R) ? AW_C : AW_R;
    localparam int DEPTH = 1 << AW;
    localparam logic [SIZE_W-1:0] LIM_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] LIM_H = SIZE_W'(MAX_HEIGHT);

    // Configuration registers.
    logic [CFG_DW-1:0] r_cfg_w;
    logic [CFG_DW-1:0] r_cfg_h;
    logic [CHAR_W-1:0] r_bg;

    // Captured transaction.
    logic [1:0]                r_kind;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [LEN_W-1:0]          r_w;
    logic [LEN_W-1:0]          r_h;
    logic                      r_fill;
    logic [CHAR_W-1:0]         r_char;
    logic [AW-1:0]             r_rd_addr;
    logic                      r_rd_oor;

    // Sequencer.
    t_state          r_state, n_state;
    logic [AW_C-1:0] r_col, n_col;
    logic [AW_R-1:0] r_row, n_row;
    t_span           r_row_span, n_row_span;

    // Canvas store.
    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_data;

    // Result register.
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_oor, n_out_oor;

    // Shared span unit operands.
    logic [PW-1:0]             su_pos;
    logic signed [COORD_W-1:0] su_org;
    logic [LEN_W-1:0]          su_len;
    t_span                     su_span;

    logic [SIZE_W-1:0] used_w;
    logic [SIZE_W-1:0] used_h;
    logic              in_acc;
    logic              empty_canvas;
    logic              last_col;
    logic              last_row;
    logic              paint;
    logic [SIZE_W-1:0] rc_ext;
    logic [SIZE_W-1:0] rr_ext;

    // Canvas in use, limited to the store geometry.
    always_comb begin
        used_w       = (SIZE_W'(r_cfg_w) > LIM_W) ? LIM_W : SIZE_W'(r_cfg_w);
        used_h       = (SIZE_W'(r_cfg_h) > LIM_H) ? LIM_H : SIZE_W'(r_cfg_h);
        empty_canvas = (used_w == '0) || (used_h == '0);
        last_col     = (SIZE_W'(r_col) + SIZE_W'(1)) == used_w;
        last_row     = (SIZE_W'(r_row) + SIZE_W'(1)) == used_h;
        in_acc       = i_in_valid && o_in_ready;
        rc_ext       = SIZE_W'(i_read_col);
        rr_ext       = SIZE_W'(i_read_row);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_CANVAS_SIZE;
            r_cfg_h <= RST_CANVAS_SIZE;
            r_bg    <= RST_BACKGROUND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CANVAS_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_BACKGROUND:    r_bg    <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind    <= i_kind;
            r_x       <= i_rect_x;
            r_y       <= i_rect_y;
            r_w       <= i_rect_width;
            r_h       <= i_rect_height;
            r_fill    <= i_filled;
            r_char    <= i_paint_char;
            r_rd_addr <= {rr_ext[AW_R-1:0], rc_ext[AW_C-1:0]};
            r_rd_oor  <= (rc_ext >= used_w) || (rr_ext >= used_h);
        end
    end

    // The span unit tests the row once per row, then each column of that row.
    always_comb begin
        if (r_state == S_ROW) begin
            su_pos = PW'(r_row);
            su_org = r_y;
            su_len = r_h;
        end else begin
            su_pos = PW'(r_col);
            su_org = r_x;
            su_len = r_w;
        end
    end

    rrc_span_unit #(
        .PW        (PW),
        .FRAC_BITS (FRAC_BITS)
    ) u_span (
        .i_pos  (su_pos),
        .i_org  (su_org),
        .i_len  (su_len),
        .o_span (su_span)
    );

    // Pixel write decision.
    always_comb begin
        paint   = su_span.covered && r_row_span.covered
                  && (r_fill || su_span.edge_band || r_row_span.edge_band);
        wr_en   = (r_state == S_COL) && ((r_kind == KIND_CLEAR) || paint);
        wr_data = (r_kind == KIND_CLEAR) ? r_bg : r_char;
    end

    // Canvas store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[{r_row, r_col}] <= wr_data;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    // Sequencer next state and result register loading.
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_row_span  = r_row_span;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_oor   = r_out_oor;
        o_in_ready  = (r_state == S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_col = '0;
                    n_row = '0;
                    case (i_kind)
                        KIND_CLEAR, KIND_DRAW: begin
                            n_state = empty_canvas ? S_IDLE : S_ROW;
                        end
                        KIND_READ: n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ROW: begin
                n_row_span = su_span;
                n_col      = '0;
                n_state    = S_COL;
            end
            S_COL: begin
                if (last_col) begin
                    if (last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + AW_R'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_col = r_col + AW_C'(1);
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_rd_oor ? '0 : r_rd_data;
                    n_out_oor   = r_rd_oor;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Counters and payload registers.
    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_row_span <= n_row_span;
        r_out_char <= n_out_char;
        r_out_oor  <= n_out_oor;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_char   = r_out_char;
    assign o_out_of_range = r_out_oor;

    // A new result only appears after a read has gone through the store.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RESULT)
        else $error("result appeared without a read");

    // The column sweep never leaves the canvas in use.
    a_col_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (SIZE_W'(r_col) < used_w) && (SIZE_W'(r_row) < used_h))
        else $error("sweep outside canvas");

    // An out-of-range answer carries a zero character.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_char == '0))
        else $error("out-of-range result with nonzero character");

    // An accepted read goes straight to the store read.
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_READ) |=> (r_state == S_READ))
        else $error("read transaction did not start a store read");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the rectangle raster canvas: predictor, driver, monitor, stimulus.
module testbench
    import rrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W    = DEF_MAX_WIDTH;
    localparam int MAX_H    = DEF_MAX_HEIGHT;
    localparam int FRAC     = DEF_FRAC_BITS;
    localparam int FRAC_ONE = 1 << FRAC;
    // The limit outlasts a 300 by 300 clear plus the pause before a register write.
    localparam int QUIET_LIMIT = 800000;
    // Kind code that the block ignores.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic [LEN_W-1:0]          rect_width;
        logic [LEN_W-1:0]          rect_height;
        logic                      filled;
        logic [CHAR_W-1:0]         paint_char;
        logic [RD_POS_W-1:0]       read_col;
        logic [RD_POS_W-1:0]       read_row;
    } t_canvas_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic              out_of_range;
    } t_pixel_answer;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_idx = CFG_CANVAS_WIDTH;
    logic [CFG_DW-1:0]         i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_kind = KIND_CLEAR;
    logic signed [COORD_W-1:0] i_rect_x = '0;
    logic signed [COORD_W-1:0] i_rect_y = '0;
    logic [LEN_W-1:0]          i_rect_width = '0;
    logic [LEN_W-1:0]          i_rect_height = '0;
    logic                      i_filled = 1'b0;
    logic [CHAR_W-1:0]         i_paint_char = '0;
    logic [RD_POS_W-1:0]       i_read_col = '0;
    logic [RD_POS_W-1:0]       i_read_row = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [CHAR_W-1:0]         o_pixel_char;
    logic                      o_out_of_range;

    rect_raster_canvas dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_rect_x       (i_rect_x),
        .i_rect_y       (i_rect_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_filled       (i_filled),
        .i_paint_char   (i_paint_char),
        .i_read_col     (i_read_col),
        .i_read_row     (i_read_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_char   (o_pixel_char),
        .o_out_of_range (o_out_of_range)
    );

    // Shadow of the configuration registers and of the canvas contents.
    logic [CFG_DW-1:0] cfg_cols = RST_CANVAS_SIZE;
    logic [CFG_DW-1:0] cfg_rows = RST_CANVAS_SIZE;
    logic [CHAR_W-1:0] bg_char  = RST_BACKGROUND;
    logic [CHAR_W-1:0] canvas_chars [0:MAX_W*MAX_H-1];
    // Pixels that some queued clear or draw will have written, used to aim reads.
    bit                planned [0:MAX_W*MAX_H-1];

    t_canvas_cmd   cmd_queue[$];
    t_pixel_answer read_answers[$];
    t_canvas_cmd   cmd_now;
    t_canvas_cmd   seen_cmd;
    t_pixel_answer answer;
    t_pixel_answer due;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            steady_flow = 1'b0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int used_w();
        return (cfg_cols > MAX_W) ? MAX_W : int'(cfg_cols);
    endfunction

    function automatic int used_h();
        return (cfg_rows > MAX_H) ? MAX_H : int'(cfg_rows);
    endfunction

    // Cycles the block needs for one clear or draw over the canvas in use, with margin.
    function automatic int work_cycles();
        return used_h() * (used_w() + 1) + 16;
    endfunction

    // A draw paints a pixel on the edge band always and inside it only when filled.
    function automatic bit pixel_painted(t_canvas_cmd c, int col, int row);
        longint pc, pr, x, y, rw, rh, one;
        one = longint'(FRAC_ONE);
        pc  = longint'(col) * one;
        pr  = longint'(row) * one;
        x   = $signed(c.rect_x);
        y   = $signed(c.rect_y);
        rw  = c.rect_width;
        rh  = c.rect_height;
        if (pc < x || pc > x + rw || pr < y || pr > y + rh)
            return 1'b0;
        if (pc - x < one || pr - y < one || x + rw - pc < one || y + rh - pr < one)
            return 1'b1;
        return c.filled;
    endfunction

    // Walks the canvas in use for a clear or draw: either marks the pixels it will write
    // or updates the shadow canvas.
    task automatic paint_pass(t_canvas_cmd c, bit plan_only);
        int w, h, idx;
        bit hit;
        w = used_w();
        h = used_h();
        for (int row = 0; row < h; row++) begin
            for (int col = 0; col < w; col++) begin
                hit = (c.kind == KIND_CLEAR) || pixel_painted(c, col, row);
                idx = row * MAX_W + col;
                if (hit && plan_only)
                    planned[idx] = 1'b1;
                else if (hit)
                    canvas_chars[idx] = (c.kind == KIND_CLEAR) ? bg_char : c.paint_char;
            end
        end
    endtask

    function automatic t_canvas_cmd rand_noise();
        bit [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_canvas_cmd)-1:0];
    endfunction

    function automatic t_canvas_cmd make_plain(logic [1:0] kind);
        t_canvas_cmd c;
        c = rand_noise();
        c.kind = kind;
        return c;
    endfunction

    function automatic t_canvas_cmd make_draw(int x, int y, int rw, int rh, bit fill, int ch);
        t_canvas_cmd c;
        c = make_plain(KIND_DRAW);
        c.rect_x      = COORD_W'(x);
        c.rect_y      = COORD_W'(y);
        c.rect_width  = LEN_W'(rw);
        c.rect_height = LEN_W'(rh);
        c.filled      = fill;
        c.paint_char  = CHAR_W'(ch);
        return c;
    endfunction

    function automatic t_canvas_cmd make_read(int col, int row);
        t_canvas_cmd c;
        c = make_plain(KIND_READ);
        c.read_col = RD_POS_W'(col);
        c.read_row = RD_POS_W'(row);
        return c;
    endfunction

    // Mostly rectangles around the canvas in use, some with whole-pixel corners so that
    // the edges fall exactly on pixels; a wild draw keeps fully random geometry.
    function automatic t_canvas_cmd rand_draw(bit wild);
        t_canvas_cmd c;
        int w, h, x, y, rw, rh;
        c = make_plain(KIND_DRAW);
        if (!wild) begin
            w  = used_w();
            h  = used_h();
            x  = int'($urandom_range((w + 6) * FRAC_ONE)) - 3 * FRAC_ONE;
            y  = int'($urandom_range((h + 6) * FRAC_ONE)) - 3 * FRAC_ONE;
            rw = int'($urandom_range((w + 2) * FRAC_ONE));
            rh = int'($urandom_range((h + 2) * FRAC_ONE));
            if ($urandom_range(1) == 1) begin
                x  = x & ~(FRAC_ONE - 1);
                y  = y & ~(FRAC_ONE - 1);
                rw = rw & ~(FRAC_ONE - 1);
                rh = rh & ~(FRAC_ONE - 1);
            end
            c.rect_x      = COORD_W'(x);
            c.rect_y      = COORD_W'(y);
            c.rect_width  = LEN_W'(rw);
            c.rect_height = LEN_W'(rh);
        end
        return c;
    endfunction

    // A read goes to a pixel already written or to a position outside the canvas in use.
    function automatic t_canvas_cmd rand_read();
        t_canvas_cmd c;
        int w, h, col, row;
        bit found;
        c = make_plain(KIND_READ);
        w = used_w();
        h = used_h();
        col = 0;
        row = 0;
        found = 1'b0;
        if (w > 0 && h > 0 && $urandom_range(3) != 0) begin
            for (int t = 0; t < 40 && !found; t++) begin
                col = int'($urandom_range(w - 1));
                row = int'($urandom_range(h - 1));
                found = planned[row * MAX_W + col];
            end
        end
        if (!found) begin
            if (w < MAX_W && (h >= MAX_H || $urandom_range(1) == 1)) begin
                col = int'($urandom_range(MAX_W - 1, w));
                row = int'($urandom_range(MAX_H - 1));
            end else if (h < MAX_H) begin
                row = int'($urandom_range(MAX_H - 1, h));
                col = int'($urandom_range(MAX_W - 1));
            end else begin
                c.kind = KIND_SPARE;
            end
        end
        c.read_col = RD_POS_W'(col);
        c.read_row = RD_POS_W'(row);
        return c;
    endfunction

    task automatic queue_cmd(t_canvas_cmd c);
        if (c.kind == KIND_CLEAR || c.kind == KIND_DRAW)
            paint_pass(c, 1'b1);
        cmd_queue.push_back(c);
    endtask

    task automatic run_random(int count, bit start_clear);
        int pick;
        if (start_clear)
            queue_cmd(make_plain(KIND_CLEAR));
        repeat (count) begin
            pick = int'($urandom_range(99));
            if (pick < 40)
                queue_cmd(rand_read());
            else if (pick < 82)
                queue_cmd(rand_draw(1'b0));
            else if (pick < 90)
                queue_cmd(rand_draw(1'b1));
            else if (pick < 95)
                queue_cmd(make_plain(KIND_CLEAR));
            else
                queue_cmd(make_plain(KIND_SPARE));
        end
    endtask

    // Waits until every queued transaction is accepted and every read has answered.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || read_answers.size() != 0);
    endtask

    // Clears and draws give no answer, so the last one may still be running.
    task automatic settle();
        wait_idle();
        repeat (work_cycles()) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // The extra edge lets the monitor take the last write into the shadow registers.
    task automatic set_canvas(int cols, int rows, int bg);
        write_reg(CFG_CANVAS_WIDTH, CFG_DW'(cols));
        write_reg(CFG_CANVAS_HEIGHT, CFG_DW'(rows));
        write_reg(CFG_BACKGROUND, {2'($urandom), CHAR_W'(bg)});
        @(posedge i_clk);
    endtask

    // Driver: presents the next transaction once the current one is taken, idling at random outside the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (cmd_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 15)) begin
                cmd_now = cmd_queue.pop_front();
                i_in_valid    <= 1'b1;
                i_kind        <= cmd_now.kind;
                i_rect_x      <= cmd_now.rect_x;
                i_rect_y      <= cmd_now.rect_y;
                i_rect_width  <= cmd_now.rect_width;
                i_rect_height <= cmd_now.rect_height;
                i_filled      <= cmd_now.filled;
                i_paint_char  <= cmd_now.paint_char;
                i_read_col    <= cmd_now.read_col;
                i_read_row    <= cmd_now.read_row;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side stalls at random outside the steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= i_rst_n && (steady_flow || $urandom_range(99) >= 15);
    end

    // Monitor: tracks register writes, predicts each accepted transaction and checks results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CANVAS_WIDTH:  cfg_cols = i_cfg_data;
                    CFG_CANVAS_HEIGHT: cfg_rows = i_cfg_data;
                    CFG_BACKGROUND:    bg_char  = i_cfg_data[CHAR_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && o_in_ready) begin
                seen_cmd.kind        = i_kind;
                seen_cmd.rect_x      = i_rect_x;
                seen_cmd.rect_y      = i_rect_y;
                seen_cmd.rect_width  = i_rect_width;
                seen_cmd.rect_height = i_rect_height;
                seen_cmd.filled      = i_filled;
                seen_cmd.paint_char  = i_paint_char;
                seen_cmd.read_col    = i_read_col;
                seen_cmd.read_row    = i_read_row;
                case (seen_cmd.kind)
                    KIND_CLEAR, KIND_DRAW: paint_pass(seen_cmd, 1'b0);
                    KIND_READ: begin
                        if (seen_cmd.read_col < used_w() && seen_cmd.read_row < used_h()) begin
                            answer.pixel_char =
                                canvas_chars[int'(seen_cmd.read_row) * MAX_W
                                             + int'(seen_cmd.read_col)];
                            answer.out_of_range = 1'b0;
                        end else begin
                            answer.pixel_char   = '0;
                            answer.out_of_range = 1'b1;
                        end
                        read_answers.push_back(answer);
                    end
                    default: ;
                endcase
            end

            if (o_out_valid && i_out_ready) begin
                if (read_answers.size() == 0) begin
                    $error("result with no read waiting: pixel_char %0d, out_of_range %0d",
                           o_pixel_char, o_out_of_range);
                    mismatches++;
                end else begin
                    due = read_answers.pop_front();
                    if (o_pixel_char !== due.pixel_char) begin
                        $error("pixel_char: expected %0d, actual %0d",
                               due.pixel_char, o_pixel_char);
                        mismatches++;
                    end
                    if (o_out_of_range !== due.out_of_range) begin
                        $error("out_of_range: expected %0d, actual %0d",
                               due.out_of_range, o_out_of_range);
                        mismatches++;
                    end
                end
            end

            // Watchdog: any transaction or register write counts as progress.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no transaction for %0d cycles, %0d reads unanswered",
                       quiet_cycles, read_answers.size());
                $display("** rect_raster_canvas: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus: directed transactions first, then random phases over several geometries.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: clear, a filled and a zero-width draw, reads inside and outside.
        queue_cmd(make_plain(KIND_CLEAR));
        queue_cmd(make_draw(10 * FRAC_ONE + 128, -3 * FRAC_ONE, 50 * FRAC_ONE,
                            20 * FRAC_ONE + 1, 1'b1, "R"));
        queue_cmd(make_draw(200 * FRAC_ONE, 150 * FRAC_ONE, 0, 30 * FRAC_ONE, 1'b0, "r"));
        queue_cmd(make_read(11, 0));
        queue_cmd(make_read(35, 10));
        queue_cmd(make_read(61, 0));
        queue_cmd(make_read(200, 165));
        queue_cmd(make_read(299, 299));
        queue_cmd(make_read(300, 5));
        queue_cmd(make_read(5, 300));
        queue_cmd(make_read(511, 511));
        queue_cmd(make_plain(KIND_SPARE));
        settle();

        // Small canvas: coordinate extremes, exact edges and a zero-height rectangle.
        set_canvas(40, 24, 255);
        queue_cmd(make_plain(KIND_CLEAR));
        queue_cmd(make_draw(-262144, -262144, 262143, 262143, 1'b0, 0));
        queue_cmd(make_draw(262143, 262143, 1, 1, 1'b1, 8'hAA));
        queue_cmd(make_draw(5 * FRAC_ONE, 4 * FRAC_ONE, 20 * FRAC_ONE, 10 * FRAC_ONE,
                            1'b0, 0));
        queue_cmd(make_draw(0, 2 * FRAC_ONE, FRAC_ONE, 0, 1'b1, 255));
        queue_cmd(make_read(5, 9));
        queue_cmd(make_read(6, 5));
        queue_cmd(make_read(25, 14));
        queue_cmd(make_read(1, 2));
        queue_cmd(make_read(39, 23));
        queue_cmd(make_read(40, 0));
        settle();

        // Oversized width, full height, and both kinds of empty canvas.
        set_canvas(1023, 3, 0);
        run_random(6, 1'b1);
        settle();
        set_canvas(1, 512, 46);
        run_random(6, 1'b1);
        settle();
        set_canvas(0, 9, 7);
        run_random(4, 1'b1);
        settle();
        set_canvas(600, 0, 99);
        run_random(3, 1'b1);
        settle();

        // Main random run; the first stretch flows with no idling, then the sender
        // holds off until every read has answered before a stretch with random idling.
        set_canvas(20, 16, int'($urandom_range(255)));
        steady_flow = 1'b1;
        run_random(15, 1'b1);
        wait_idle();
        steady_flow = 1'b0;
        run_random(20, 1'b0);
        settle();

        // Shrink and grow without clearing: stored pixels keep their positions.
        set_canvas(10, 8, int'($urandom_range(255)));
        run_random(6, 1'b0);
        settle();
        set_canvas(28, 20, int'($urandom_range(255)));
        run_random(10, 1'b0);
        settle();

        if (mismatches == 0)
            $display("** rect_raster_canvas: PASSED **");
        else
            $display("** rect_raster_canvas: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rrc_pkg.sv
design/rrc_span_unit.sv
design/rect_raster_canvas.sv
bench/testbench.sv
